FILE: sv/packed_name_char_decoder_top_assert.svh
// Assertion macros for the packed name character decoder top level.
`ifndef PACKED_NAME_CHAR_DECODER_TOP_ASSERT_SVH
`define PACKED_NAME_CHAR_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pndc_pkg.sv
// Types, constants and decode functions shared by the packed name decoder.
package pndc_pkg;

    localparam logic [2:0] ENC_UTF8        = 3'd0;
    localparam logic [2:0] ENC_LOWER       = 3'd1;
    localparam logic [2:0] ENC_LUD         = 3'd2;
    localparam logic [2:0] ENC_FIRST_UPPER = 3'd3;
    localparam logic [2:0] ENC_ESCAPED     = 3'd4;

    localparam logic [0:0] REG_SPECIAL_A = 1'd0;
    localparam logic [0:0] REG_SPECIAL_B = 1'd1;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [7:0] SPECIAL_A_RESET = 8'd46;
    localparam logic [7:0] SPECIAL_B_RESET = 8'd95;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_DOT     = 8'h2e;
    localparam logic [7:0] CHAR_UNDER   = 8'h5f;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_PIPE    = 8'h7c;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    localparam logic [2:0] CODE5_BITS = 3'd5;
    localparam logic [2:0] CODE6_BITS = 3'd6;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] encoding;
        logic       first_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_valid;
        logic       end_of_string;
        logic       bad_code;
        logic       run_last;
    } out_t;

    // Up to three results caused by one request, packed in order from slot 0.
    typedef struct packed {
        out_t [MAX_RES-1:0] res;
        logic [1:0]         cnt;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } q_link_t;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           data;
    } cfg_wr_t;

    typedef struct packed {
        logic err;
        logic fcp;
        logic esc;
    } rel_st_t;

    typedef struct packed {
        rel_st_t st;
        logic    put;
        out_t    res;
    } rel_out_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    // Decodes one released code and updates the per-string flags.
    function automatic rel_out_t release_code(input logic [5:0] code,
                                              input logic [2:0] enc,
                                              input rel_st_t    st,
                                              input logic [7:0] spa,
                                              input logic [7:0] spb);
        rel_out_t   r;
        logic [7:0] ch;
        logic [7:0] code8;
        logic       bad;
        r     = '0;
        r.st  = st;
        ch    = '0;
        bad   = 1'b0;
        code8 = {2'b00, code};
        if (!st.err) begin
            if (enc == ENC_LUD) begin
                if (code inside {[6'd0:6'd25]}) begin
                    ch = CHAR_LOWER_A + code8;
                end else if (code inside {[6'd26:6'd51]}) begin
                    ch = CHAR_UPPER_A + code8 - 8'd26;
                end else if (code inside {[6'd52:6'd61]}) begin
                    ch = CHAR_ZERO + code8 - 8'd52;
                end else if (code == 6'd62) begin
                    ch = spa;
                end else begin
                    ch = spb;
                end
            end else begin
                if (code inside {[6'd0:6'd25]}) begin
                    ch = CHAR_LOWER_A + code8;
                end else if (code == 6'd26) begin
                    ch = CHAR_DOT;
                end else if (code == 6'd27) begin
                    ch = CHAR_UNDER;
                end else if (code == 6'd28) begin
                    ch = CHAR_DOLLAR;
                end else if (code == 6'd29) begin
                    ch = CHAR_PIPE;
                end else begin
                    bad = 1'b1;
                end
            end
            if (bad) begin
                r.put          = 1'b1;
                r.res.bad_code = 1'b1;
                r.st.err       = 1'b1;
            end else begin
                if (enc == ENC_FIRST_UPPER && st.fcp) begin
                    ch = to_upper(ch);
                end
                r.st.fcp = 1'b0;
                if (enc == ENC_ESCAPED) begin
                    if (st.esc) begin
                        r.st.esc         = 1'b0;
                        r.put            = 1'b1;
                        r.res.char_code  = to_upper(ch);
                        r.res.char_valid = 1'b1;
                    end else if (ch == CHAR_PIPE) begin
                        r.st.esc = 1'b1;
                    end else begin
                        r.put            = 1'b1;
                        r.res.char_code  = ch;
                        r.res.char_valid = 1'b1;
                    end
                end else begin
                    r.put            = 1'b1;
                    r.res.char_code  = ch;
                    r.res.char_valid = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/pndc_front.sv
// Front end: accepts bytes, holds the string state and builds result bundles.
module pndc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pndc_pkg::in_t     s_data,
    input  pndc_pkg::cfg_wr_t cfg_wr,
    input  logic              q_full,
    output pndc_pkg::q_link_t q_wr
);

    logic [7:0]        spa_reg;
    logic [7:0]        spb_reg;
    logic [12:0]       acc_reg, acc_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              strip_reg, strip_next;
    logic [5:0]        held_reg, held_next;
    logic              hv_reg, hv_next;
    pndc_pkg::rel_st_t rs_reg, rs_next;

    logic    accept;
    logic    coded;
    logic [2:0] k;
    logic [3:0] sh;
    logic [12:0] shifted;
    logic [5:0] code;
    logic [1:0] n;
    pndc_pkg::rel_out_t ro;
    pndc_pkg::out_t [pndc_pkg::MAX_RES-1:0] res;
    pndc_pkg::out_t tail;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign coded   = s_data.encoding inside {[pndc_pkg::ENC_LOWER:pndc_pkg::ENC_ESCAPED]};
    assign k       = (s_data.encoding == pndc_pkg::ENC_LUD) ? pndc_pkg::CODE6_BITS
                                                           : pndc_pkg::CODE5_BITS;

    always_comb begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        strip_next  = strip_reg;
        held_next   = held_reg;
        hv_next     = hv_reg;
        rs_next     = rs_reg;
        res         = '0;
        n           = 2'd0;
        sh          = '0;
        shifted     = '0;
        code        = '0;
        ro          = '0;
        tail        = '0;

        if (s_data.first_byte) begin
            acc_next   = '0;
            cnt_next   = '0;
            strip_next = 1'b0;
            held_next  = '0;
            hv_next    = 1'b0;
            rs_next    = '{err: 1'b0, fcp: 1'b1, esc: 1'b0};
        end

        if (!coded) begin
            tail.char_code  = s_data.data_byte;
            tail.char_valid = 1'b1;
            res[n]          = tail;
            n               = n + 2'd1;
        end else if (!rs_next.err) begin
            if (s_data.first_byte) begin
                strip_next = s_data.data_byte[7];
                acc_next   = {6'd0, s_data.data_byte[6:0]};
                cnt_next   = 4'd7;
            end else begin
                acc_next = {acc_next[4:0], s_data.data_byte};
                cnt_next = cnt_next + 4'd8;
            end
            // A byte yields at most two codes, whatever the bits left over.
            for (int i = 0; i < 2; i++) begin
                if (!rs_next.err && cnt_next >= {1'b0, k}) begin
                    sh      = cnt_next - {1'b0, k};
                    shifted = acc_next >> sh;
                    code    = (k == pndc_pkg::CODE6_BITS) ? shifted[5:0]
                                                          : {1'b0, shifted[4:0]};
                    cnt_next = sh;
                    acc_next = acc_next & ((13'd1 << cnt_next) - 13'd1);
                    if (hv_next) begin
                        ro      = pndc_pkg::release_code(held_next, s_data.encoding, rs_next,
                                                         spa_reg, spb_reg);
                        rs_next = ro.st;
                        if (ro.put && n != 2'd3) begin
                            res[n] = ro.res;
                            n      = n + 2'd1;
                        end
                    end
                    held_next = code;
                    hv_next   = 1'b1;
                end
            end
        end

        if (s_data.last_byte) begin
            if (coded && hv_next && !strip_next) begin
                ro      = pndc_pkg::release_code(held_next, s_data.encoding, rs_next,
                                                 spa_reg, spb_reg);
                rs_next = ro.st;
                if (ro.put && n != 2'd3) begin
                    res[n] = ro.res;
                    n      = n + 2'd1;
                end
            end
            if (n == 2'd0) begin
                tail          = '0;
                tail.bad_code = rs_next.err;
                res[n]        = tail;
                n             = n + 2'd1;
            end
            res[n - 2'd1].end_of_string = 1'b1;
            acc_next   = '0;
            cnt_next   = '0;
            strip_next = 1'b0;
            held_next  = '0;
            hv_next    = 1'b0;
            rs_next    = '{err: 1'b0, fcp: 1'b1, esc: 1'b0};
        end

        if (n != 2'd0) begin
            res[n - 2'd1].run_last = 1'b1;
        end
    end

    assign q_wr.valid      = accept && (n != 2'd0);
    assign q_wr.bundle.res = res;
    assign q_wr.bundle.cnt = n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spa_reg   <= pndc_pkg::SPECIAL_A_RESET;
            spb_reg   <= pndc_pkg::SPECIAL_B_RESET;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            strip_reg <= 1'b0;
            held_reg  <= '0;
            hv_reg    <= 1'b0;
            rs_reg    <= '{err: 1'b0, fcp: 1'b1, esc: 1'b0};
        end else begin
            if (cfg_wr.en && cfg_wr.idx == pndc_pkg::REG_SPECIAL_A) begin
                spa_reg <= cfg_wr.data;
            end
            if (cfg_wr.en && cfg_wr.idx == pndc_pkg::REG_SPECIAL_B) begin
                spb_reg <= cfg_wr.data;
            end
            if (accept) begin
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                strip_reg <= strip_next;
                held_reg  <= held_next;
                hv_reg    <= hv_next;
                rs_reg    <= rs_next;
            end
        end
    end

endmodule

FILE: sv/pndc_queue.sv
// Short first-in first-out queue of result bundles between front and back.
module pndc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pndc_pkg::q_link_t q_wr,
    output logic              q_full,
    output pndc_pkg::q_link_t q_rd,
    input  logic              q_pop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pndc_pkg::bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign q_full      = (count_reg == CNT_W'(DEPTH));
    assign q_rd.valid  = (count_reg != '0);
    assign q_rd.bundle = mem_reg[rd_ptr_reg];
    assign push        = q_wr.valid && !q_full;
    assign pop         = q_pop && q_rd.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= q_wr.bundle;
        end
    end

endmodule

FILE: sv/pndc_back.sv
// Back end: hands out the results of each bundle through an output register.
module pndc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  pndc_pkg::q_link_t q_rd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output pndc_pkg::out_t    m_data
);

    logic [1:0]     idx_reg, idx_next;
    logic           m_valid_reg, m_valid_next;
    pndc_pkg::out_t m_data_reg;
    logic           load;
    logic           last_slot;

    assign load      = q_rd.valid && (!m_valid_reg || m_ready);
    assign last_slot = (idx_reg == q_rd.bundle.cnt - 2'd1);
    assign q_pop     = load && last_slot;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            idx_next     = last_slot ? 2'd0 : idx_reg + 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= q_rd.bundle.res[idx_reg];
        end
    end

endmodule

FILE: sv/packed_name_char_decoder_top.sv
// Path: an accepted request's results are written into the queue memory and then, one at
// a time, into the output register that drives m_data.
// Throughput: one request per cycle is taken while the queue has room; the output side
// hands out one result per cycle while the receiver keeps taking them.
// Reset: aresetn is synchronous and active low; it empties the queue and output register,
// clears the string state and restores both special character registers.
`include "packed_name_char_decoder_top_assert.svh"

module packed_name_char_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pndc_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pndc_pkg::out_t                 m_data,
    input  logic                           cfg_wr_en,
    input  logic [pndc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_wr_data
);

    // The front end decodes each request combinationally: it unpacks up to two codes
    // from the bit accumulator, releases the code held back from before, and on the
    // last byte of a string releases the held code unless the strip flag asks for it
    // to be dropped. All results a request causes are gathered into one bundle.
    pndc_pkg::cfg_wr_t cfg_wr;
    pndc_pkg::q_link_t q_wr;
    pndc_pkg::q_link_t q_rd;
    logic              q_full;
    logic              q_pop;
    logic              in_last_acc;
    logic              m_eos;
    logic              m_empty;
    logic              m_empty_ok;

    assign cfg_wr.en   = cfg_wr_en;
    assign cfg_wr.idx  = cfg_index;
    assign cfg_wr.data = cfg_wr_data;

    pndc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg_wr  (cfg_wr),
        .q_full  (q_full),
        .q_wr    (q_wr)
    );

    // The queue lets the front end carry on with new bytes while the back end is still
    // handing out the characters of an earlier byte, or while the output is stalled.
    pndc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_rd    (q_rd),
        .q_pop   (q_pop)
    );

    // The back end walks through the bundle at the head of the queue, one result per
    // cycle while the receiver keeps up, into an output register that keeps the two sides apart.
    pndc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_rd    (q_rd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Short names for the conditions that the checks below look at.
    assign in_last_acc = s_valid && s_ready && s_data.last_byte;
    assign m_eos       = m_valid && m_data.end_of_string;
    assign m_empty     = m_valid && !m_data.char_valid;
    assign m_empty_ok  = m_data.run_last && (m_data.char_code == 8'd0);

    // A string's final byte always causes at least one result, so a bundle must be
    // waiting in the queue in the following cycle.
    `PNDC_ASSERT_NEXT(a_last_byte_queued, in_last_acc, q_rd.valid, "last byte left no bundle")
    // The end of a string is always marked on the final result of its request.
    `PNDC_ASSERT_SAME(a_eos_is_run_last, m_eos, m_data.run_last, "end of string not last")
    // A result without a character is either an error or an end marker and ends the request.
    `PNDC_ASSERT_SAME(a_empty_result_last, m_empty, m_empty_ok, "empty result not final")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the packed name character decoder top level.
module tb;

    // Five-bit codes that do not decode to a letter, and the first special six-bit code.
    localparam logic [5:0] CODE_DOT       = 6'd26;
    localparam logic [5:0] CODE_UNDER     = 6'd27;
    localparam logic [5:0] CODE_DOLLAR    = 6'd28;
    localparam logic [5:0] CODE_PIPE      = 6'd29;
    localparam logic [5:0] CODE_SPECIAL_A = 6'd62;
    localparam logic [5:0] CODE_LAST_LUD  = 6'd61;
    localparam logic [5:0] CODE_LAST_UPPR = 6'd51;
    localparam logic [5:0] CODE_LAST_LOW  = 6'd25;
    localparam logic [5:0] CODE_FIRST_UP  = 6'd26;
    localparam logic [5:0] CODE_FIRST_DIG = 6'd52;

    localparam int CYCLE_LIMIT = 200000;

    // Clock, reset and the ports of the block. Every input starts at a known value.
    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    pndc_pkg::in_t                  s_data      = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    pndc_pkg::out_t                 m_data;
    logic                           cfg_wr_en   = 1'b0;
    logic [pndc_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [7:0]                     cfg_wr_data = '0;

    // Requests waiting to be offered, and characters the block still owes us.
    pndc_pkg::in_t  pending_bytes[$];
    pndc_pkg::out_t chars_due[$];
    pndc_pkg::out_t step_results[$];

    // Our own copy of the special character registers.
    logic [7:0] special_a = pndc_pkg::SPECIAL_A_RESET;
    logic [7:0] special_b = pndc_pkg::SPECIAL_B_RESET;

    // Our own copy of the per-string decoding state.
    logic [12:0] acc_bits      = '0;
    logic [3:0]  acc_count     = '0;
    logic        strip_pending = 1'b0;
    logic [5:0]  held_code     = '0;
    logic        held_valid    = 1'b0;
    logic        first_pending = 1'b1;
    logic        escape_armed  = 1'b0;
    logic        str_error     = 1'b0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int phase;
    logic [7:0] new_a;
    logic [7:0] new_b;

    packed_name_char_decoder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor of the decoder.
    // ------------------------------------------------------------------

    // Returns every string-level flag to its idle value; the registers are kept.
    task automatic clear_string_state();
        acc_bits      = '0;
        acc_count     = '0;
        strip_pending = 1'b0;
        held_code     = '0;
        held_valid    = 1'b0;
        first_pending = 1'b1;
        escape_armed  = 1'b0;
        str_error     = 1'b0;
    endtask

    // A single request never gives more than three results; any beyond that are lost.
    task automatic emit_result(input logic [7:0] ch, input logic valid, input logic bad);
        pndc_pkg::out_t r;
        r = '0;
        r.char_code  = ch;
        r.char_valid = valid;
        r.bad_code   = bad;
        if (step_results.size() < pndc_pkg::MAX_RES) begin
            step_results = {step_results, r};
        end
    endtask

    function automatic logic [7:0] upcase_letter(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= pndc_pkg::CHAR_LOWER_A && c <= pndc_pkg::CHAR_LOWER_Z) begin
            r = c - pndc_pkg::CASE_OFFSET;
        end
        return r;
    endfunction

    // Turns a code that has stopped being the newest one into a character, if any.
    task automatic release_held(input logic [5:0] code, input logic [2:0] enc);
        logic [7:0] ch;
        logic       bad;
        ch  = '0;
        bad = 1'b0;
        if (!str_error) begin
            if (enc == pndc_pkg::ENC_LUD) begin
                if (code <= CODE_LAST_LOW) begin
                    ch = pndc_pkg::CHAR_LOWER_A + code;
                end else if (code <= CODE_LAST_UPPR) begin
                    ch = pndc_pkg::CHAR_UPPER_A + (code - CODE_FIRST_UP);
                end else if (code <= CODE_LAST_LUD) begin
                    ch = pndc_pkg::CHAR_ZERO + (code - CODE_FIRST_DIG);
                end else if (code == CODE_SPECIAL_A) begin
                    ch = special_a;
                end else begin
                    ch = special_b;
                end
            end else begin
                if (code <= CODE_LAST_LOW) begin
                    ch = pndc_pkg::CHAR_LOWER_A + code;
                end else if (code == CODE_DOT) begin
                    ch = pndc_pkg::CHAR_DOT;
                end else if (code == CODE_UNDER) begin
                    ch = pndc_pkg::CHAR_UNDER;
                end else if (code == CODE_DOLLAR) begin
                    ch = pndc_pkg::CHAR_DOLLAR;
                end else if (code == CODE_PIPE) begin
                    ch = pndc_pkg::CHAR_PIPE;
                end else begin
                    bad = 1'b1;
                end
            end
            if (bad) begin
                emit_result(8'h00, 1'b0, 1'b1);
                str_error = 1'b1;
            end else begin
                if (enc == pndc_pkg::ENC_FIRST_UPPER && first_pending) begin
                    ch = upcase_letter(ch);
                end
                first_pending = 1'b0;
                if (enc == pndc_pkg::ENC_ESCAPED) begin
                    if (escape_armed) begin
                        escape_armed = 1'b0;
                        emit_result(upcase_letter(ch), 1'b1, 1'b0);
                    end else if (ch == pndc_pkg::CHAR_PIPE) begin
                        escape_armed = 1'b1;
                    end else begin
                        emit_result(ch, 1'b1, 1'b0);
                    end
                end else begin
                    emit_result(ch, 1'b1, 1'b0);
                end
            end
        end
    endtask

    // Works out every character an accepted request releases and queues them.
    task automatic decode_request(input pndc_pkg::in_t req);
        logic [2:0]     enc;
        logic           coded;
        int             k;
        int             code_v;
        pndc_pkg::out_t r;
        step_results.delete();
        enc   = req.encoding;
        coded = (enc >= pndc_pkg::ENC_LOWER && enc <= pndc_pkg::ENC_ESCAPED);
        if (req.first_byte) begin
            clear_string_state();
        end
        if (!coded) begin
            emit_result(req.data_byte, 1'b1, 1'b0);
        end else if (!str_error) begin
            k = (enc == pndc_pkg::ENC_LUD) ? 6 : 5;
            if (req.first_byte) begin
                strip_pending = req.data_byte[7];
                acc_bits      = {6'b0, req.data_byte[6:0]};
                acc_count     = 4'd7;
            end else begin
                acc_bits  = {acc_bits[4:0], req.data_byte};
                acc_count = acc_count + 4'd8;
            end
            while (!str_error && acc_count >= k) begin
                code_v    = int'((acc_bits >> (acc_count - k)) & ((1 << k) - 1));
                acc_count = 4'(acc_count - k);
                acc_bits  = 13'(acc_bits & ((1 << acc_count) - 1));
                if (held_valid) begin
                    release_held(held_code, enc);
                end
                held_code  = code_v[5:0];
                held_valid = 1'b1;
            end
        end
        if (req.last_byte) begin
            if (coded && held_valid && !strip_pending) begin
                release_held(held_code, enc);
            end
            if (step_results.size() == 0) begin
                emit_result(8'h00, 1'b0, str_error);
            end
            step_results[step_results.size() - 1].end_of_string = 1'b1;
            clear_string_state();
        end
        foreach (step_results[i]) begin
            r = step_results[i];
            r.run_last = (i == step_results.size() - 1);
            chars_due = {chars_due, r};
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    task automatic add_request(input logic [7:0] data_v, input logic [2:0] enc,
                               input logic first, input logic last);
        pndc_pkg::in_t req;
        req.data_byte  = data_v;
        req.encoding   = enc;
        req.first_byte = first;
        req.last_byte  = last;
        pending_bytes = {pending_bytes, req};
    endtask

    function automatic logic [2:0] pick_encoding();
        int r;
        logic [2:0] enc;
        r = $urandom_range(0, 11);
        if (r == 0) begin
            enc = pndc_pkg::ENC_UTF8;
        end else if (r == 1) begin
            enc = 3'($urandom_range(7, pndc_pkg::ENC_ESCAPED + 1));
        end else begin
            enc = 3'(pndc_pkg::ENC_LOWER + ((r - 2) % 4));
        end
        return enc;
    endfunction

    // Mostly well-formed strings with random content; the rest is loose noise,
    // strings with a missing mark and strings that switch encoding part way.
    task automatic queue_random_strings(input int n_items);
        int         count;
        int         len;
        logic [2:0] enc;
        logic [7:0] data_v;
        logic       first;
        logic       last;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                add_request(8'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
                count++;
            end else begin
                enc = pick_encoding();
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    data_v = 8'($urandom);
                    // Thinning the ones keeps most strings clear of the invalid codes.
                    if ($urandom_range(0, 1) == 1) begin
                        data_v = data_v & 8'($urandom);
                    end
                    first = (i == 0) && ($urandom_range(0, 19) != 0);
                    last  = (i == len - 1) && ($urandom_range(0, 19) != 0);
                    add_request(data_v,
                                ($urandom_range(0, 9) == 0) ? pick_encoding() : enc,
                                first, last);
                    count++;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input pndc_pkg::out_t want,
                                   input pndc_pkg::out_t got);
        string want_s;
        string got_s;
        mismatch_count++;
        if (mismatch_count <= 10) begin
            want_s = $sformatf("code %02h valid %0b eos %0b bad %0b last %0b",
                               want.char_code, want.char_valid, want.end_of_string,
                               want.bad_code, want.run_last);
            got_s  = $sformatf("code %02h valid %0b eos %0b bad %0b last %0b",
                               got.char_code, got.char_valid, got.end_of_string,
                               got.bad_code, got.run_last);
            $display("%s: expected %s, got %s", what, want_s, got_s);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the oldest pending request, with random gaps. A request
    // that is accepted at this edge is handed to the predictor first, using
    // the payload as it stood before the edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_request(s_data);
            end
            // The payload may only change once the current request has gone.
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data  <= pending_bytes.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result taken is compared with the oldest character owed.
    // Ready is redrawn every cycle, so stalls land on every stage of the work.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (chars_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_data);
                end else if (m_data.char_code     !== chars_due[0].char_code  ||
                             m_data.char_valid    !== chars_due[0].char_valid ||
                             m_data.end_of_string !== chars_due[0].end_of_string ||
                             m_data.bad_code      !== chars_due[0].bad_code   ||
                             m_data.run_last      !== chars_due[0].run_last) begin
                    report_mismatch("wrong result", chars_due[0], m_data);
                    void'(chars_due.pop_front());
                end else begin
                    void'(chars_due.pop_front());
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // A hung block would otherwise keep the run going for ever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("packed_name_char_decoder_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, then three phases. Each phase sets its idling and, after
    // the first, writes the special characters while the block is quiet; then it
    // queues its requests and waits for every owed character to come out.
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 29;
                    new_a = 8'h00;
                    new_b = 8'hFF;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    new_a = 8'hFF;
                    new_b = 8'h00;
                end
            endcase

            if (phase != 0) begin
                @(posedge aclk);
                cfg_wr_en   <= 1'b1;
                cfg_index   <= pndc_pkg::REG_SPECIAL_A;
                cfg_wr_data <= new_a;
                @(posedge aclk);
                cfg_index   <= pndc_pkg::REG_SPECIAL_B;
                cfg_wr_data <= new_b;
                @(posedge aclk);
                cfg_wr_en   <= 1'b0;
                special_a = new_a;
                special_b = new_b;
            end

            if (phase == 0) begin
                // Pass-through at both byte extremes, and an unknown encoding.
                add_request(8'h00, pndc_pkg::ENC_UTF8, 1'b1, 1'b1);
                add_request(8'hFF, pndc_pkg::ENC_UTF8, 1'b1, 1'b1);
                add_request(8'hA5, 3'(pndc_pkg::ENC_ESCAPED + 3), 1'b1, 1'b1);
                // One lower-case letter, then the same with the strip flag set.
                add_request(8'h08, pndc_pkg::ENC_LOWER, 1'b1, 1'b1);
                add_request(8'h88, pndc_pkg::ENC_LOWER, 1'b1, 1'b1);
                // An invalid code at the end, then one hidden by the strip flag.
                add_request(8'h7C, pndc_pkg::ENC_LOWER, 1'b1, 1'b1);
                add_request(8'hFC, pndc_pkg::ENC_LOWER, 1'b1, 1'b1);
                // An invalid code part way through silences the rest of the string.
                add_request(8'h7C, pndc_pkg::ENC_LOWER, 1'b1, 1'b0);
                add_request(8'h00, pndc_pkg::ENC_LOWER, 1'b0, 1'b1);
                add_request(8'h7C, pndc_pkg::ENC_LOWER, 1'b1, 1'b0);
                add_request(8'hFF, pndc_pkg::ENC_LOWER, 1'b0, 1'b0);
                add_request(8'h00, pndc_pkg::ENC_LOWER, 1'b0, 1'b1);
                // Capitalised first letter, three characters out of one request.
                add_request(8'h00, pndc_pkg::ENC_FIRST_UPPER, 1'b1, 1'b0);
                add_request(8'h00, pndc_pkg::ENC_FIRST_UPPER, 1'b0, 1'b1);
                // Escape before a letter, then a trailing escape that is dropped.
                add_request(8'h74, pndc_pkg::ENC_ESCAPED, 1'b1, 1'b0);
                add_request(8'h00, pndc_pkg::ENC_ESCAPED, 1'b0, 1'b1);
                add_request(8'h74, pndc_pkg::ENC_ESCAPED, 1'b1, 1'b1);
                // Bytes with no first mark carry on from the idle state.
                add_request(8'h12, pndc_pkg::ENC_LOWER, 1'b0, 1'b0);
                add_request(8'h34, pndc_pkg::ENC_LOWER, 1'b0, 1'b1);
                // Encoding changes inside one string, including pass-through.
                add_request(8'h08, pndc_pkg::ENC_LOWER, 1'b1, 1'b0);
                add_request(8'h41, pndc_pkg::ENC_UTF8, 1'b0, 1'b0);
                add_request(8'hFF, pndc_pkg::ENC_LUD, 1'b0, 1'b1);
                // A six-bit code too large for a five-bit encoding when released.
                add_request(8'h7E, pndc_pkg::ENC_LUD, 1'b1, 1'b0);
                add_request(8'h00, pndc_pkg::ENC_LOWER, 1'b0, 1'b1);
            end

            // Both special characters under the settings of this phase.
            add_request(8'h7C, pndc_pkg::ENC_LUD, 1'b1, 1'b1);
            add_request(8'h7E, pndc_pkg::ENC_LUD, 1'b1, 1'b1);
            queue_random_strings((phase == 2) ? 80 : 75);

            // Wait until everything has been offered, taken and answered.
            do begin
                @(posedge aclk);
            end while (pending_bytes.size() != 0 || s_valid || chars_due.size() != 0);
            // Requests that release nothing may still be inside the block.
            repeat (8) @(posedge aclk);
        end

        if (mismatch_count == 0 && chars_due.size() == 0) begin
            $display("packed_name_char_decoder_top test passed");
        end else begin
            $display("packed_name_char_decoder_top test failed");
        end
        $finish;
    end

endmodule
